// ===== design/skv_pkg.sv =====
`default_nettype none

package skv_pkg;

	localparam int TABLE_DEPTH = 8;
	localparam int KEY_BITS    = 32;
	localparam int VALUE_BITS  = 32;
	localparam int MODE_W      = 3;
	localparam int STATUS_W    = 2;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LOOKUP    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_HAS_KEY   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_HAS_VALUE = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DUP_KEY   = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0]     mode;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic                  found;
		logic [VALUE_BITS-1:0] read_value;
		logic [CNT_W-1:0]      entry_count;
	} rsp_t;

endpackage

`default_nettype wire

// ===== design/skv_table.sv =====
`default_nettype none

module skv_table
	import skv_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire req_t req,
	input  wire logic commit,
	output rsp_t      result
);

	logic [KEY_BITS-1:0]   key_store_q   [TABLE_DEPTH];
	logic [VALUE_BITS-1:0] value_store_q [TABLE_DEPTH];
	logic [CNT_W-1:0]      fill_q;

	logic [TABLE_DEPTH-1:0] key_hit;
	logic [TABLE_DEPTH-1:0] value_hit;
	logic [TABLE_DEPTH-1:0] at_or_above;
	logic                   any_key;
	logic                   any_value;
	logic                   full;
	logic [VALUE_BITS-1:0]  hit_value;
	logic                   do_insert;
	logic                   do_remove;
	logic [CNT_W-1:0]       next_fill;

	// compare every valid slot in parallel
	always_comb begin
		hit_value = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			key_hit[i]   = (CNT_W'(i) < fill_q) && (key_store_q[i] == req.key);
			value_hit[i] = (CNT_W'(i) < fill_q) && (value_store_q[i] == req.value);
			if (key_hit[i])
				hit_value = hit_value | value_store_q[i];
		end
		at_or_above[0] = key_hit[0];
		for (int i = 1; i < TABLE_DEPTH; i++)
			at_or_above[i] = at_or_above[i-1] | key_hit[i];
	end

	assign any_key   = |key_hit;
	assign any_value = |value_hit;
	assign full      = (fill_q >= CNT_W'(TABLE_DEPTH));

	always_comb begin
		result.status      = STATUS_OK;
		result.found       = 1'b0;
		result.read_value  = '0;
		do_insert          = 1'b0;
		do_remove          = 1'b0;
		case (req.mode)
			MODE_INSERT: begin
				if (any_key) begin
					result.status = STATUS_DUP_KEY;
					result.found  = 1'b1;
				end else if (full) begin
					result.status = STATUS_FULL;
				end else begin
					do_insert = 1'b1;
				end
			end
			MODE_LOOKUP: begin
				if (any_key) begin
					result.found      = 1'b1;
					result.read_value = hit_value;
				end else begin
					result.status = STATUS_NOT_FOUND;
				end
			end
			MODE_REMOVE: begin
				if (any_key) begin
					result.found = 1'b1;
					do_remove    = 1'b1;
				end else begin
					result.status = STATUS_NOT_FOUND;
				end
			end
			MODE_HAS_KEY: begin
				if (any_key)
					result.found = 1'b1;
				else
					result.status = STATUS_NOT_FOUND;
			end
			MODE_HAS_VALUE: begin
				if (any_value)
					result.found = 1'b1;
				else
					result.status = STATUS_NOT_FOUND;
			end
			default: begin
			end
		endcase
		next_fill = fill_q;
		if (do_insert)
			next_fill = fill_q + CNT_W'(1);
		else if (do_remove)
			next_fill = fill_q - CNT_W'(1);
		result.entry_count = next_fill;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (commit) begin
			fill_q <= next_fill;
		end
	end

	// slot-wise update: append at the fill point, or move later entries down one
	for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_slot
		always_ff @(posedge clk) begin
			if (commit && do_insert && (fill_q[IDX_W-1:0] == IDX_W'(gi))) begin
				key_store_q[gi]   <= req.key;
				value_store_q[gi] <= req.value;
			end
			if (gi < TABLE_DEPTH - 1) begin
				if (commit && do_remove && at_or_above[gi]) begin
					key_store_q[gi]   <= key_store_q[(gi + 1) % TABLE_DEPTH];
					value_store_q[gi] <= value_store_q[(gi + 1) % TABLE_DEPTH];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/small_key_value_table.sv =====
// A request word is captured in the request register; its result word is then
// registered onto rsp once the result register is empty or being taken.
// Throughput: one request per cycle while the consumer holds rsp_ready high; the
// table is searched and updated between the request and result registers.
// Reset (arst_n low) empties the table and clears both stage valids; key and
// value slots are not cleared and are only read once written.
`default_nettype none

module small_key_value_table
	import skv_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	logic valid_s1;
	req_t req_s1;
	logic rsp_valid_q;
	rsp_t rsp_q;
	rsp_t result;
	logic advance;

	assign advance   = !rsp_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || advance;

	skv_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_s1),
		.commit (valid_s1 && advance),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_ready)
				valid_s1 <= req_valid;
			if (advance)
				rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready)
			req_s1 <= req;
		// hold the result word while the consumer stalls
		if (advance && valid_s1)
			rsp_q <= result;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== design/skv_chk.sv =====
`default_nettype none

module skv_chk
	import skv_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result word changed while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.entry_count <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found |-> rsp.status == STATUS_OK || rsp.status == STATUS_DUP_KEY)
		else $error("found with a miss or full status");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.read_value == '0)
		else $error("read value without a hit");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STATUS_FULL |-> rsp.entry_count == CNT_W'(TABLE_DEPTH))
		else $error("full status below depth");

endmodule

bind small_key_value_table skv_chk u_skv_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire

// ===== tb/kv_table_checker.sv =====
module kv_table_checker
	import skv_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	input  wire logic req_ready,
	input  wire req_t req,
	input  wire logic rsp_valid,
	input  wire logic rsp_ready,
	input  wire rsp_t rsp,
	output int        mismatches,
	output int        replies_due
);

	logic [KEY_BITS-1:0]   held_keys [TABLE_DEPTH];
	logic [VALUE_BITS-1:0] held_values [TABLE_DEPTH];
	int                    entries_held;
	rsp_t                  expected_replies [$];

	// Update the table copy for one request and return the reply it must give.
	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		int   slot;
		o = '0;
		slot = -1;
		for (int i = 0; i < entries_held; i++) begin
			if (slot < 0 && held_keys[i] == r.key)
				slot = i;
		end
		case (r.mode)
			MODE_INSERT: begin
				if (slot >= 0) begin
					o.status = STATUS_DUP_KEY;
					o.found = 1'b1;
				end else if (entries_held >= TABLE_DEPTH) begin
					o.status = STATUS_FULL;
				end else begin
					held_keys[entries_held] = r.key;
					held_values[entries_held] = r.value;
					entries_held++;
				end
			end
			MODE_LOOKUP: begin
				if (slot >= 0) begin
					o.found = 1'b1;
					o.read_value = held_values[slot];
				end else begin
					o.status = STATUS_NOT_FOUND;
				end
			end
			MODE_REMOVE: begin
				if (slot >= 0) begin
					o.found = 1'b1;
					// close the gap: later entries move down one slot
					for (int i = slot; i < entries_held - 1; i++) begin
						held_keys[i] = held_keys[i + 1];
						held_values[i] = held_values[i + 1];
					end
					entries_held--;
				end else begin
					o.status = STATUS_NOT_FOUND;
				end
			end
			MODE_HAS_KEY: begin
				if (slot >= 0)
					o.found = 1'b1;
				else
					o.status = STATUS_NOT_FOUND;
			end
			MODE_HAS_VALUE: begin
				for (int i = 0; i < entries_held; i++) begin
					if (held_values[i] == r.value)
						o.found = 1'b1;
				end
				if (!o.found)
					o.status = STATUS_NOT_FOUND;
			end
			default: begin
			end
		endcase
		o.entry_count = CNT_W'(entries_held);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			expected_replies.delete();
			entries_held = 0;
			mismatches = 0;
			replies_due = 0;
		end else begin
			// check the outgoing word before queuing the one coming in
			if (rsp_valid && rsp_ready) begin
				if (expected_replies.size() == 0) begin
					$error("reply word with no request outstanding: %p", rsp);
					mismatches++;
				end else begin
					want = expected_replies.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						mismatches++;
					end
					if (rsp.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp.found);
						mismatches++;
					end
					if (rsp.read_value !== want.read_value) begin
						$error("read_value: expected %h, got %h",
							want.read_value, rsp.read_value);
						mismatches++;
					end
					if (rsp.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, rsp.entry_count);
						mismatches++;
					end
				end
			end
			if (req_valid && req_ready)
				expected_replies.push_back(apply_request(req));
			replies_due = expected_replies.size();
		end
	end

endmodule

// ===== tb/small_key_value_table_tb.sv =====
module small_key_value_table_tb;
	import skv_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;
	localparam logic [KEY_BITS-1:0]   KEY_ONES   = '1;
	localparam logic [VALUE_BITS-1:0] VALUE_ONES = '1;
	localparam int ITEMS_PER_PHASE = 284;
	localparam int HOLDOFF_CYCLES  = 60;
	localparam int DRAIN_LIMIT     = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	int   mismatches;
	int   replies_due;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int insert_pct;
	int remove_pct;
	int holdoffs_asked = 0;
	int holdoffs_done = 0;

	logic [KEY_BITS-1:0]   key_pool [16];
	logic [VALUE_BITS-1:0] value_pool [8];

	small_key_value_table uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	kv_table_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.mismatches(mismatches),
		.replies_due(replies_due)
	);

	always #1 clk = ~clk;

	initial begin
		#400000;
		$display("FAILURE");
		$finish;
	end

	// Enter and leave at a falling edge; hold the word until it is taken.
	task automatic send(input logic [MODE_W-1:0] mode, input logic [KEY_BITS-1:0] key,
			input logic [VALUE_BITS-1:0] value);
		req_t w;
		w.mode = mode;
		w.key = key;
		w.value = value;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do
			@(posedge clk);
		while (!req_ready);
		@(negedge clk);
	endtask

	task automatic send_random();
		int                    r;
		int                    s;
		logic [MODE_W-1:0]     mode;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
		r = $urandom_range(0, 99);
		s = $urandom_range(0, 15);
		if (r < insert_pct)
			mode = MODE_INSERT;
		else if (r < insert_pct + remove_pct)
			mode = MODE_REMOVE;
		else if (s < 5)
			mode = MODE_LOOKUP;
		else if (s < 10)
			mode = MODE_HAS_KEY;
		else if (s < 15)
			mode = MODE_HAS_VALUE;
		else
			mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
		key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 15)] : $urandom;
		value = ($urandom_range(0, 99) < 70) ? value_pool[$urandom_range(0, 7)] : $urandom;
		send(mode, key, value);
	endtask

	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (holdoffs_done != holdoffs_asked) begin
				holdoffs_done++;
				// hold off long enough for the block to back up into its input
				for (int i = 0; i < HOLDOFF_CYCLES; i++) begin
					rsp_ready <= 1'b0;
					@(negedge clk);
				end
			end
			rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	initial begin
		int waited;
		key_pool[0] = '0;
		key_pool[1] = KEY_ONES;
		for (int i = 2; i < 16; i++)
			key_pool[i] = $urandom;
		value_pool[0] = '0;
		value_pool[1] = VALUE_ONES;
		for (int i = 2; i < 8; i++)
			value_pool[i] = $urandom;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table, extremes, duplicates, full table, compaction, spare modes
		send(MODE_LOOKUP, '0, '0);
		send(MODE_REMOVE, '0, '0);
		send(MODE_HAS_VALUE, '0, '0);
		send(MODE_INSERT, '0, VALUE_ONES);
		send(MODE_INSERT, KEY_ONES, '0);
		send(MODE_INSERT, '0, 32'd1);
		send(MODE_LOOKUP, '0, '0);
		send(MODE_LOOKUP, KEY_ONES, VALUE_ONES);
		send(MODE_HAS_KEY, KEY_ONES, '0);
		send(MODE_HAS_KEY, 32'd5, '0);
		send(MODE_HAS_VALUE, '0, '0);
		send(MODE_HAS_VALUE, '0, 32'h5555_5555);
		for (int i = 1; i <= 6; i++)
			send(MODE_INSERT, KEY_BITS'(i), 32'hA5A5_0000 + VALUE_BITS'(i));
		send(MODE_INSERT, 32'd7, 32'd7);
		send(MODE_INSERT, '0, 32'd9);
		send(MODE_REMOVE, '0, '0);
		send(MODE_REMOVE, 32'd6, '0);
		send(MODE_REMOVE, 32'd3, '0);
		send(MODE_LOOKUP, 32'd4, '0);
		send(MODE_SPARE_LO, KEY_ONES, VALUE_ONES);
		send(MODE_SPARE_MID, 32'd1, 32'd1);
		send(MODE_SPARE_HI, '0, '0);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 7;
					rx_idle_pct = 77;
					insert_pct = 45;
					remove_pct = 15;
				end
				1: begin
					tx_idle_pct = 77;
					rx_idle_pct = 7;
					insert_pct = 20;
					remove_pct = 40;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					insert_pct = 35;
					remove_pct = 25;
					holdoffs_asked++;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_random();
		end
		req_valid <= 1'b0;

		waited = 0;
		while (replies_due != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(negedge clk);
		if (replies_due != 0)
			$error("%0d reply words never arrived", replies_due);
		if (mismatches == 0 && replies_due == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/skv_pkg.sv
design/skv_table.sv
design/small_key_value_table.sv
design/skv_chk.sv
tb/kv_table_checker.sv
tb/small_key_value_table_tb.sv
